@@ rtl/tte_pkg.sv @@
// Shared types and constants for the table ANS encoder.
`default_nettype none
package tte_pkg;
	localparam int FREQ_W      = 12;
	localparam int RUN_W       = 20;
	localparam int FILL_W      = 5;
	localparam int CMP_W       = 14;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_W     = 1;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_BUILD  = 2'd1;
	localparam logic [1:0] REQ_ENCODE = 2'd2;
	localparam logic [1:0] REQ_FINISH = 2'd3;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_FINAL = 2'd1;
	localparam logic [1:0] KIND_BUILD = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  symbol;
		logic [11:0] frequency;
	} tte_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  byte_value;
		logic [10:0] final_state;
		logic [31:0] bit_count;
		logic        build_ok;
		logic        last;
	} tte_out_t;

	// classified request as it sits in the queue
	typedef struct packed {
		logic [1:0]  op;
		logic        sym_ok;
		logic [7:0]  symbol;
		logic [11:0] frequency;
	} tte_cmd_t;
endpackage
`default_nettype wire

@@ rtl/tte_front.sv @@
// Front end: accepts request items, classifies them and queues them.
`default_nettype none
module tte_front import tte_pkg::*; #(
	parameter int SYMBOL_COUNT = 256
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire tte_in_t  in_item,
	output logic          cmd_valid,
	input  wire logic     cmd_ready,
	output tte_cmd_t      cmd
);
	tte_cmd_t             q_q [QUEUE_DEPTH];
	logic [QUEUE_W-1:0]   wp_q, rp_q;
	logic [QUEUE_W:0]     cnt_q;
	tte_cmd_t             cls;
	logic                 push, pop;

	always_comb begin
		cls.op        = in_item.req_type;
		cls.sym_ok    = ({1'b0, in_item.symbol} < 9'(SYMBOL_COUNT));
		cls.symbol    = in_item.symbol;
		cls.frequency = in_item.frequency;
	end

	assign in_ready  = (cnt_q != (QUEUE_W + 1)'(QUEUE_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= cls;
	end
endmodule
`default_nettype wire

@@ rtl/tte_back.sv @@
// Back end: table memories, build sequencer, coder and output register.
`default_nettype none
module tte_back import tte_pkg::*; #(
	parameter int TABLE_LOG    = 11,
	parameter int SYMBOL_COUNT = 256
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_ready,
	input  wire tte_cmd_t cmd,
	output logic          out_valid,
	input  wire logic     out_ready,
	output tte_out_t      out_item
);
	localparam int TL     = TABLE_LOG;
	localparam int SW     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int L      = 1 << TL;
	localparam int XW     = TL + 1;
	localparam int NBW    = $clog2(TL + 2);
	localparam int AW     = TL + 8;
	localparam int STRIDE = ((L >> 1) + (L >> 3) + 3) | 1;

	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_ERR   = 18'h00002,
		S_ENC2  = 18'h00004,
		S_ENC3  = 18'h00008,
		S_ENC4  = 18'h00010,
		S_BYTE  = 18'h00020,
		S_FBYTE = 18'h00040,
		S_FREC  = 18'h00080,
		S_SUMRD = 18'h00100,
		S_SUMWR = 18'h00200,
		S_CHK   = 18'h00400,
		S_SPRRD = 18'h00800,
		S_SPRF  = 18'h01000,
		S_SPRW  = 18'h02000,
		S_BE1   = 18'h04000,
		S_BE2   = 18'h08000,
		S_BE3   = 18'h10000,
		S_BRES  = 18'h20000
	} st_t;

	st_t                 state_q;
	logic                ready_q;
	logic                ok_q;
	logic [TL-1:0]       coder_q;
	logic [AW-1:0]       acc_q;
	logic [FILL_W-1:0]   fill_q;
	logic [31:0]         total_q;
	logic                out_valid_q;
	tte_out_t            out_item_q;

	logic [FREQ_W-1:0]   freq_mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] fv_q;
	logic [TL-1:0]       cum_mem [SYMBOL_COUNT];
	logic [TL-1:0]       next_mem [SYMBOL_COUNT];
	logic [SW-1:0]       spread_mem [L];
	logic [TL-1:0]       enc_mem [L];

	logic [FREQ_W-1:0]   freq_rd_q;
	logic                fv_rd_q;
	logic [TL-1:0]       cum_rd_q, next_rd_q, enc_rd_q;
	logic [SW-1:0]       spread_rd_q;

	logic [SW-1:0]       s_q, sym_q;
	logic [TL-1:0]       pos_q, i_q, cum_q;
	logic [FREQ_W-1:0]   k_q, f_q;
	logic [RUN_W-1:0]    run_q;
	logic [NBW-1:0]      nb_q;
	logic [XW-1:0]       t_q, bits_q;

	logic                slot_free, emit;
	tte_out_t            eo;
	logic [FREQ_W-1:0]   f_eff;
	logic [SW-1:0]       freq_ra, cum_ra;
	logic [CMP_W-1:0]    enc_sum;
	logic [TL-1:0]       enc_ra;
	logic [XW-1:0]       xs, ge, bits_c, t_c;
	logic [CMP_W-1:0]    two_f;
	logic [NBW-1:0]      nb_c;
	logic [TL+10:0]      fs_ext;
	logic                load_we;

	assign slot_free = !out_valid_q || out_ready;
	assign f_eff     = fv_rd_q ? freq_rd_q : '0;
	assign freq_ra   = (state_q == S_IDLE) ? cmd.symbol[SW-1:0] : s_q;
	assign cum_ra    = (state_q == S_IDLE) ? cmd.symbol[SW-1:0] : spread_rd_q;
	assign enc_sum   = CMP_W'(cum_q) + CMP_W'(t_q) - CMP_W'(f_q);
	assign enc_ra    = enc_sum[TL-1:0];
	assign cmd_ready = (state_q == S_IDLE);
	assign load_we   = (state_q == S_IDLE) && cmd_valid && (cmd.op == REQ_LOAD) && cmd.sym_ok;
	assign fs_ext    = {11'b0, coder_q};
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// shift count: ge is a thermometer code, one bit per shift still needed
	always_comb begin
		xs    = {1'b1, coder_q};
		two_f = {1'b0, f_eff, 1'b0};
		nb_c  = '0;
		for (int n = 0; n < XW; n++) begin
			ge[n] = (CMP_W'(xs >> n) >= two_f);
		end
		for (int n = 0; n < XW; n++) begin
			if (ge[n]) nb_c = NBW'(n + 1);
		end
		bits_c = xs & ge;
		t_c    = xs >> nb_c;
	end

	always_comb begin
		emit = 1'b0;
		eo   = '0;
		case (state_q)
			S_ERR: begin
				emit    = 1'b1;
				eo.kind = KIND_ERROR;
				eo.last = 1'b1;
			end
			S_BYTE: begin
				emit          = 1'b1;
				eo.kind       = KIND_BYTE;
				eo.byte_value = acc_q[7:0];
				eo.last       = (fill_q < FILL_W'(16));
			end
			S_FBYTE: begin
				emit          = (fill_q != '0);
				eo.kind       = KIND_BYTE;
				eo.byte_value = acc_q[7:0];
			end
			S_FREC: begin
				emit           = 1'b1;
				eo.kind        = KIND_FINAL;
				eo.final_state = fs_ext[10:0];
				eo.bit_count   = total_q;
				eo.last        = 1'b1;
			end
			S_BRES: begin
				emit        = 1'b1;
				eo.kind     = KIND_BUILD;
				eo.build_ok = ok_q;
				eo.last     = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ready_q     <= 1'b0;
			coder_q     <= '0;
			acc_q       <= '0;
			fill_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			fv_q        <= '0;
		end else begin
			if (emit && slot_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (load_we) fv_q[cmd.symbol[SW-1:0]] <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							REQ_LOAD: ready_q <= 1'b0;
							REQ_BUILD: begin
								ready_q <= 1'b0;
								state_q <= S_SUMRD;
							end
							REQ_ENCODE: begin
								if (!cmd.sym_ok || !ready_q) state_q <= S_ERR;
								else state_q <= S_ENC2;
							end
							default: state_q <= S_FBYTE;
						endcase
					end
				end
				S_ERR: if (slot_free) state_q <= S_IDLE;
				S_ENC2: begin
					if (f_eff == '0) state_q <= S_ERR;
					else state_q <= S_ENC3;
				end
				S_ENC3: begin
					acc_q   <= acc_q | (AW'(bits_q) << fill_q);
					fill_q  <= fill_q + FILL_W'(nb_q);
					total_q <= total_q + 32'(nb_q);
					state_q <= S_ENC4;
				end
				S_ENC4: begin
					coder_q <= enc_rd_q;
					if (fill_q >= FILL_W'(8)) state_q <= S_BYTE;
					else state_q <= S_IDLE;
				end
				S_BYTE: begin
					if (slot_free) begin
						acc_q  <= acc_q >> 8;
						fill_q <= fill_q - FILL_W'(8);
						if (fill_q < FILL_W'(16)) state_q <= S_IDLE;
					end
				end
				S_FBYTE: begin
					if (fill_q == '0 || slot_free) state_q <= S_FREC;
				end
				S_FREC: begin
					if (slot_free) begin
						coder_q <= '0;
						acc_q   <= '0;
						fill_q  <= '0;
						total_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_SUMRD: state_q <= S_SUMWR;
				S_SUMWR: begin
					if (s_q == SW'(SYMBOL_COUNT - 1)) state_q <= S_CHK;
					else state_q <= S_SUMRD;
				end
				S_CHK: begin
					if (run_q == RUN_W'(L)) state_q <= S_SPRRD;
					else state_q <= S_BRES;
				end
				S_SPRRD: state_q <= S_SPRF;
				S_SPRF: begin
					if (f_eff != '0) state_q <= S_SPRW;
					else if (s_q == SW'(SYMBOL_COUNT - 1)) state_q <= S_BE1;
					else state_q <= S_SPRRD;
				end
				S_SPRW: begin
					if (k_q == f_q - 1'b1) begin
						if (s_q == SW'(SYMBOL_COUNT - 1)) state_q <= S_BE1;
						else state_q <= S_SPRRD;
					end
				end
				S_BE1: state_q <= S_BE2;
				S_BE2: state_q <= S_BE3;
				S_BE3: begin
					if (i_q == TL'(L - 1)) begin
						ready_q <= 1'b1;
						state_q <= S_BRES;
					end else begin
						state_q <= S_BE1;
					end
				end
				S_BRES: if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath and sequencer counters
	always_ff @(posedge clk) begin
		if (emit && slot_free) out_item_q <= eo;
		case (state_q)
			S_IDLE: begin
				s_q   <= '0;
				run_q <= '0;
			end
			S_ENC2: begin
				f_q    <= f_eff;
				cum_q  <= cum_rd_q;
				nb_q   <= nb_c;
				t_q    <= t_c;
				bits_q <= bits_c;
			end
			S_SUMWR: begin
				run_q <= run_q + RUN_W'(f_eff);
				s_q   <= s_q + 1'b1;
			end
			S_CHK: begin
				s_q   <= '0;
				pos_q <= '0;
				ok_q  <= (run_q == RUN_W'(L));
			end
			S_SPRF: begin
				k_q <= '0;
				f_q <= f_eff;
				if (f_eff == '0) s_q <= s_q + 1'b1;
				i_q <= '0;
			end
			S_SPRW: begin
				pos_q <= pos_q + TL'(STRIDE);
				k_q   <= k_q + 1'b1;
				if (k_q == f_q - 1'b1) s_q <= s_q + 1'b1;
				i_q <= '0;
			end
			S_BE2: sym_q <= spread_rd_q;
			S_BE3: i_q <= i_q + 1'b1;
			default: begin
			end
		endcase
	end

	// memories, one write and one registered read each
	always_ff @(posedge clk) begin
		if (load_we) freq_mem[cmd.symbol[SW-1:0]] <= cmd.frequency;
		freq_rd_q <= freq_mem[freq_ra];
		fv_rd_q   <= fv_q[freq_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SUMWR) cum_mem[s_q] <= run_q[TL-1:0];
		cum_rd_q <= cum_mem[cum_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SUMWR) next_mem[s_q] <= '0;
		else if (state_q == S_BE3) next_mem[sym_q] <= next_rd_q + 1'b1;
		next_rd_q <= next_mem[spread_rd_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SPRW) spread_mem[pos_q] <= s_q;
		spread_rd_q <= spread_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_BE3) enc_mem[cum_rd_q + next_rd_q] <= i_q;
		enc_rd_q <= enc_mem[enc_ra];
	end

`ifndef SYNTHESIS
	a_idle_no_whole_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (fill_q < FILL_W'(8)))
		else $error("whole byte left unsent");
	a_build_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPRW || state_q == S_BE1 || state_q == S_BE2 || state_q == S_BE3)
		|-> !ready_q)
		else $error("tables flagged ready during build");
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREC && slot_free) |=>
		(fill_q == '0 && total_q == '0 && coder_q == '0))
		else $error("coder not cleared after finish");
`endif
endmodule
`default_nettype wire

@@ rtl/tans_table_encoder_top.sv @@
// Top level of the table ANS encoder.
`default_nettype none
// Table ANS (FSE style) encoder. Request items load symbol frequencies, build the
// spread and encode tables, encode one symbol (in reverse message order) or finish
// the stream. A two-entry request queue decouples the input from the sequencer, and
// an output register holds one result item, so requests keep flowing while a result
// waits. Items are worked one at a time: an encode goes through the registered
// freq/cumulative read and the registered encode-table read that feeds the next
// coder state, then sends each whole packed byte; an encode may instead end in an
// error result; a finish ends in the final record; every result also waits as
// long as out_ready holds it back. A build walks the frequency store twice, writes
// every spread slot, and then fills each encode-table entry in turn. No clearing
// pass is needed after reset.
module tans_table_encoder_top import tte_pkg::*; #(
	parameter int TABLE_LOG    = 11,
	parameter int SYMBOL_COUNT = 256
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire tte_in_t in_item,
	output logic         out_valid,
	input  wire logic    out_ready,
	output tte_out_t     out_item
);
	logic     cmd_valid;
	logic     cmd_ready;
	tte_cmd_t cmd;

	tte_front #(
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	tte_back #(
		.TABLE_LOG   (TABLE_LOG),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);
endmodule
`default_nettype wire
